### rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

  localparam int DEF_CAPACITY       = 16;
  localparam int DEF_ELEM_WIDTH     = 32;
  localparam int DEF_PRIORITY_WIDTH = 16;

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ENQ_CHK,
    ST_ENQ_CMP,
    ST_DEQ_CHK,
    ST_DEQ_CMP,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic enq_init;
    logic deq_init;
    logic rd;
    logic wr_new;
    logic wr_up;
    logic wr_down;
    logic finish;
    err_t err;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic full;
    logic empty;
    logic k_zero;
    logic k_end;
    logic lt;
  } status_t;

endpackage

### rtl/spq_ctrl.sv
// Controller of the sorted priority queue: sequences insertion and removal.
// Depends on spq_pkg; drives spq_datapath through cmd_t, reads status_t.
module spq_ctrl
  import spq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.err    = ERR_OK;
    busy       = (state != ST_IDLE);
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.op == OP_ENQ) begin
          if (status.full) begin
            cmd.finish = 1'b1;
            cmd.err    = ERR_FULL;
            state_next = ST_FIN;
          end else begin
            cmd.enq_init = 1'b1;
            state_next   = ST_ENQ_CHK;
          end
        end else begin
          if (status.empty) begin
            cmd.finish = 1'b1;
            cmd.err    = ERR_EMPTY;
            state_next = ST_FIN;
          end else begin
            cmd.deq_init = 1'b1;
            state_next   = ST_DEQ_CHK;
          end
        end
      end
      // walk from the tail towards the head, moving lower-or-equal entries up
      ST_ENQ_CHK: begin
        if (status.k_zero) begin
          cmd.wr_new = 1'b1;
          cmd.finish = 1'b1;
          state_next = ST_FIN;
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_ENQ_CMP;
        end
      end
      ST_ENQ_CMP: begin
        if (status.lt) begin
          cmd.wr_new = 1'b1;
          cmd.finish = 1'b1;
          state_next = ST_FIN;
        end else begin
          cmd.wr_up  = 1'b1;
          state_next = ST_ENQ_CHK;
        end
      end
      ST_DEQ_CHK: begin
        if (status.k_end) begin
          cmd.finish = 1'b1;
          state_next = ST_FIN;
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_DEQ_CMP;
        end
      end
      ST_DEQ_CMP: begin
        cmd.wr_down = 1'b1;
        state_next  = ST_DEQ_CHK;
      end
      ST_FIN: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/spq_datapath.sv
// Datapath of the sorted priority queue: slot memory, walk index, head and count.
// Depends on spq_pkg; commanded by spq_ctrl.
module spq_datapath
  import spq_pkg::*;
#(
  parameter int CAPACITY       = DEF_CAPACITY,
  parameter int ELEM_WIDTH     = DEF_ELEM_WIDTH,
  parameter int PRIORITY_WIDTH = DEF_PRIORITY_WIDTH,
  localparam int AW            = $clog2(CAPACITY),
  localparam int CW            = $clog2(CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output status_t                   status,
  input  logic                      op,
  input  logic [ELEM_WIDTH-1:0]     elem,
  input  logic [PRIORITY_WIDTH-1:0] priority_req,
  output logic [ELEM_WIDTH-1:0]     head_elem,
  output logic [PRIORITY_WIDTH-1:0] head_priority,
  output logic [CW-1:0]             count,
  output logic                      empty_res,
  output logic [1:0]                error
);

  logic [ELEM_WIDTH-1:0]     elem_mem [CAPACITY];
  logic [PRIORITY_WIDTH-1:0] prio_mem [CAPACITY];

  logic                      op_q;
  logic [ELEM_WIDTH-1:0]     elem_q;
  logic [PRIORITY_WIDTH-1:0] prio_q;
  logic [CW-1:0]             k;
  logic [CW-1:0]             cnt;
  logic [ELEM_WIDTH-1:0]     head_e;
  logic [PRIORITY_WIDTH-1:0] head_p;
  logic [ELEM_WIDTH-1:0]     rd_e;
  logic [PRIORITY_WIDTH-1:0] rd_p;
  err_t                      err_q;

  logic [CW-1:0] k_dec;
  logic [CW-1:0] rd_idx;

  assign k_dec  = k - CW'(1);
  assign rd_idx = (op_q == OP_ENQ) ? k_dec : k;

  assign status.op     = op_q;
  assign status.full   = (cnt == CW'(CAPACITY));
  assign status.empty  = (cnt == '0);
  assign status.k_zero = (k == '0);
  assign status.k_end  = (k >= cnt);
  assign status.lt     = (prio_q < rd_p);

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_e <= elem_mem[rd_idx[AW-1:0]];
      rd_p <= prio_mem[rd_idx[AW-1:0]];
    end
    if (cmd.wr_new) begin
      elem_mem[k[AW-1:0]] <= elem_q;
      prio_mem[k[AW-1:0]] <= prio_q;
    end else if (cmd.wr_up) begin
      elem_mem[k[AW-1:0]] <= rd_e;
      prio_mem[k[AW-1:0]] <= rd_p;
    end else if (cmd.wr_down) begin
      elem_mem[k_dec[AW-1:0]] <= rd_e;
      prio_mem[k_dec[AW-1:0]] <= rd_p;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op;
      elem_q <= elem;
      prio_q <= priority_req;
    end
    if (cmd.enq_init) begin
      k <= cnt;
    end else if (cmd.deq_init) begin
      k <= CW'(1);
    end else if (cmd.wr_up) begin
      k <= k_dec;
    end else if (cmd.wr_down) begin
      k <= k + CW'(1);
    end
    // new head on removal is the entry read from slot one
    if (cmd.wr_down && k == CW'(1)) begin
      head_e <= rd_e;
      head_p <= rd_p;
    end
    if (cmd.finish && cmd.err == ERR_OK && op_q == OP_ENQ &&
        (cnt == '0 || prio_q >= head_p)) begin
      head_e <= elem_q;
      head_p <= prio_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      err_q <= ERR_OK;
    end else if (cmd.finish) begin
      err_q <= cmd.err;
      if (cmd.err == ERR_OK) begin
        if (op_q == OP_ENQ) begin
          cnt <= cnt + CW'(1);
        end else begin
          cnt <= cnt - CW'(1);
        end
      end
    end
  end

  assign empty_res     = (cnt == '0);
  assign head_elem     = empty_res ? '0 : head_e;
  assign head_priority = empty_res ? '0 : head_p;
  assign count         = cnt;
  assign error         = err_q;

endmodule

### rtl/sorted_priority_queue.sv
// Sorted priority queue, highest priority at the head, ties leave last-in first-out.
// An enqueue moves each lower-or-equal entry one slot towards the tail and a dequeue moves
// every remaining entry one slot towards the head; each step is one slot memory read and
// one write. One item at a time; busy is low again after the strobe.
// Synchronous reset empties the queue; slot contents stay unknown until written.
// The result is shown for one cycle on done and cannot be held off.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY       = DEF_CAPACITY,
  parameter int ELEM_WIDTH     = DEF_ELEM_WIDTH,
  parameter int PRIORITY_WIDTH = DEF_PRIORITY_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             op,
  input  logic [ELEM_WIDTH-1:0]            elem,
  input  logic [PRIORITY_WIDTH-1:0]        priority_req,
  output logic                             done,
  output logic [ELEM_WIDTH-1:0]            head_elem,
  output logic [PRIORITY_WIDTH-1:0]        head_priority,
  output logic [$clog2(CAPACITY + 1)-1:0]  count,
  output logic                             empty_res,
  output logic [1:0]                       error
);

  cmd_t    cmd;
  status_t status;
  logic    ctrl_busy;

  spq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (ctrl_busy),
    .done   (done)
  );

  spq_datapath #(
    .CAPACITY       (CAPACITY),
    .ELEM_WIDTH     (ELEM_WIDTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .op            (op),
    .elem          (elem),
    .priority_req  (priority_req),
    .head_elem     (head_elem),
    .head_priority (head_priority),
    .count         (count),
    .empty_res     (empty_res),
    .error         (error)
  );

  assign busy = ctrl_busy;

endmodule

### rtl/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg for error codes and defaults.
module spq_checker
  import spq_pkg::*;
#(
  parameter int CAPACITY       = DEF_CAPACITY,
  parameter int ELEM_WIDTH     = DEF_ELEM_WIDTH,
  parameter int PRIORITY_WIDTH = DEF_PRIORITY_WIDTH
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic [ELEM_WIDTH-1:0]           head_elem,
  input logic [PRIORITY_WIDTH-1:0]       head_priority,
  input logic [$clog2(CAPACITY + 1)-1:0] count,
  input logic                            empty_res,
  input logic [1:0]                      error
);

  localparam int CW = $clog2(CAPACITY + 1);

  // an accepted item keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted item did not raise busy");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (empty_res == (count == '0)) && (count <= CW'(CAPACITY)))
    else $error("empty flag or count inconsistent");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    done && empty_res |-> head_elem == '0 && head_priority == '0)
    else $error("head not zero on empty queue");

  a_full_err: assert property (@(posedge clk) disable iff (rst)
    done && error == ERR_FULL |-> count == CW'(CAPACITY))
    else $error("full error while not full");

  a_empty_err: assert property (@(posedge clk) disable iff (rst)
    done && error == ERR_EMPTY |-> empty_res)
    else $error("empty error while entries held");

endmodule

bind sorted_priority_queue spq_checker #(
  .CAPACITY       (CAPACITY),
  .ELEM_WIDTH     (ELEM_WIDTH),
  .PRIORITY_WIDTH (PRIORITY_WIDTH)
) u_spq_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .head_elem     (head_elem),
  .head_priority (head_priority),
  .count         (count),
  .empty_res     (empty_res),
  .error         (error)
);

### verif/testbench.sv
// Self-checking testbench for sorted_priority_queue: directed items, then random phases.
// Depends on spq_pkg and the sorted_priority_queue RTL; a scoreboard class predicts each result.
`timescale 1ns / 100ps

typedef struct packed {
  logic [spq_pkg::DEF_ELEM_WIDTH-1:0]     head_elem;
  logic [spq_pkg::DEF_PRIORITY_WIDTH-1:0] head_priority;
  logic [4:0]                             count;
  logic                                   empty_res;
  spq_pkg::err_t                          error;
} head_report_t;

class queue_scoreboard;
  localparam int CAP = spq_pkg::DEF_CAPACITY;

  logic [spq_pkg::DEF_ELEM_WIDTH-1:0]     slot_elem[CAP];
  logic [spq_pkg::DEF_PRIORITY_WIDTH-1:0] slot_prio[CAP];
  int                                     held;
  head_report_t                           due_reports[$];
  int                                     fails;

  function void clear();
    held = 0;
    fails = 0;
    due_reports.delete();
  endfunction

  // Accepted item: update the predicted queue and queue up the expected report.
  function void note_item(logic o, logic [spq_pkg::DEF_ELEM_WIDTH-1:0] e,
                          logic [spq_pkg::DEF_PRIORITY_WIDTH-1:0] p);
    head_report_t rep;
    int pos;
    rep.error = spq_pkg::ERR_OK;
    if (o == spq_pkg::OP_ENQ) begin
      if (held >= CAP) begin
        rep.error = spq_pkg::ERR_FULL;
      end else begin
        pos = 0;
        while (pos < held && p < slot_prio[pos]) pos++;
        for (int k = held; k > pos; k--) begin
          slot_elem[k] = slot_elem[k-1];
          slot_prio[k] = slot_prio[k-1];
        end
        slot_elem[pos] = e;
        slot_prio[pos] = p;
        held++;
      end
    end else begin
      if (held == 0) begin
        rep.error = spq_pkg::ERR_EMPTY;
      end else begin
        for (int k = 1; k < held; k++) begin
          slot_elem[k-1] = slot_elem[k];
          slot_prio[k-1] = slot_prio[k];
        end
        held--;
      end
    end
    if (held > 0) begin
      rep.head_elem     = slot_elem[0];
      rep.head_priority = slot_prio[0];
      rep.empty_res     = 1'b0;
    end else begin
      rep.head_elem     = '0;
      rep.head_priority = '0;
      rep.empty_res     = 1'b1;
    end
    rep.count = held[4:0];
    due_reports.push_back(rep);
  endfunction

  function void check_result(head_report_t got);
    head_report_t want;
    if (due_reports.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("unexpected result: elem %h prio %h count %0d empty %b err %0d",
                 got.head_elem, got.head_priority, got.count, got.empty_res, got.error);
      return;
    end
    want = due_reports.pop_front();
    if (got.head_elem !== want.head_elem || got.head_priority !== want.head_priority ||
        got.count !== want.count || got.empty_res !== want.empty_res ||
        got.error !== want.error) begin
      fails++;
      if (fails <= 10)
        $display("mismatch: want %h %h %0d %b %0d; got %h %h %0d %b %0d",
                 want.head_elem, want.head_priority, want.count, want.empty_res, want.error,
                 got.head_elem, got.head_priority, got.count, got.empty_res, got.error);
    end
  endfunction

  function int pending();
    return due_reports.size();
  endfunction
endclass

module testbench;
  import spq_pkg::*;

  localparam int CAP      = DEF_CAPACITY;
  localparam int EW       = DEF_ELEM_WIDTH;
  localparam int PW       = DEF_PRIORITY_WIDTH;
  localparam int N_RANDOM = 2000;
  localparam int STALL_LIMIT = 2000;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  logic          op;
  logic [EW-1:0] elem;
  logic [PW-1:0] priority_req;
  logic          done;
  logic [EW-1:0] head_elem;
  logic [PW-1:0] head_priority;
  logic [$clog2(CAP + 1)-1:0] count;
  logic          empty_res;
  logic [1:0]    error;

  queue_scoreboard sb;
  int            quiet_cycles;

  sorted_priority_queue #(
    .CAPACITY(CAP),
    .ELEM_WIDTH(EW),
    .PRIORITY_WIDTH(PW)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .elem(elem),
    .priority_req(priority_req),
    .done(done),
    .head_elem(head_elem),
    .head_priority(head_priority),
    .count(count),
    .empty_res(empty_res),
    .error(error)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Called just after a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic o, input logic [EW-1:0] e, input logic [PW-1:0] p);
    start        = 1'b1;
    op           = o;
    elem         = e;
    priority_req = p;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic hold_off(input int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [PW-1:0] pick_priority(input int mode);
    case (mode)
      0: return PW'($urandom_range(0, 3));        // dense ties
      1: return PW'($urandom);
      default: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return '1;
          default: return PW'($urandom);
        endcase
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        sb.check_result('{head_elem, head_priority, count, empty_res, err_t'(error)});
      if (start && !busy)
        sb.note_item(op, elem, priority_req);
    end
  end

  // watchdog: no item accepted and no result for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int sent;
    int phase_len;
    int enq_pct;
    int prio_mode;
    int idle_pct;
    logic o;

    sb = new();
    sb.clear();
    rst          = 1'b1;
    start        = 1'b0;
    op           = OP_ENQ;
    elem         = '0;
    priority_req = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed: empty dequeue, extremes, ties, fill up, overflow, a few removals
    send_item(OP_DEQ, '1, '1);
    send_item(OP_ENQ, '1, '0);
    send_item(OP_ENQ, '0, '1);
    send_item(OP_ENQ, 32'haaaa5555, 16'd5);
    send_item(OP_ENQ, 32'h5555aaaa, 16'd5);
    send_item(OP_ENQ, 32'h12345678, 16'd5);
    send_item(OP_ENQ, 32'h0f0f0f0f, 16'd0);
    for (int i = 0; i < CAP - 6; i++)
      send_item(OP_ENQ, $urandom, PW'(i * 7919));
    send_item(OP_ENQ, 32'hdeadbeef, 16'd100);
    send_item(OP_ENQ, 32'hfeedface, '1);
    repeat (4) send_item(OP_DEQ, $urandom, PW'($urandom));

    // random phases that swing the queue between full and empty
    sent = 0;
    while (sent < N_RANDOM) begin
      phase_len = $urandom_range(30, 120);
      case ($urandom_range(0, 2))
        0: enq_pct = 85;
        1: enq_pct = 15;
        default: enq_pct = 50;
      endcase
      prio_mode = $urandom_range(0, 2);
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 35;
      endcase
      for (int i = 0; i < phase_len && sent < N_RANDOM; i++) begin
        // no idling in the last tenth of the run
        if (sent < N_RANDOM * 9 / 10 && $urandom_range(0, 99) < idle_pct)
          hold_off($urandom_range(1, 18));
        o = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        send_item(o, $urandom, pick_priority(prio_mode));
        sent++;
      end
    end
    start = 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
